// ----- hw/rtl/crtu_pkg.sv -----
package crtu_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int DEPTH_LIMIT_DEF   = 200;

  localparam int ADDR_W   = 32;
  localparam int DEPTH_W  = 8;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Input commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TRACE = 1'b1;

  // Jump opcodes
  localparam logic [1:0] OP_JAL  = 2'd1;
  localparam logic [1:0] OP_JALR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRACE_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 2'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic src_hit;
    logic dst_hit;
  } match_t;

endpackage

// ----- hw/rtl/crtu_table.sv -----
module crtu_table #(
  parameter int TABLE_ENTRIES = crtu_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  crtu_pkg::entry_t     wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output crtu_pkg::entry_t     rd_data
);
  import crtu_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/crtu_match.sv -----
module crtu_match (
  input  crtu_pkg::entry_t                entry,
  input  logic [crtu_pkg::ADDR_W-1:0]     src_addr,
  input  logic [crtu_pkg::ADDR_W-1:0]     dst_addr,
  output crtu_pkg::match_t                result
);
  import crtu_pkg::*;

  logic [ADDR_W-1:0] range_end;

  // End wraps modulo 2^32; a wrapped end matches nothing
  assign range_end = entry.start + entry.size;

  always_comb begin
    result.src_hit = (src_addr >= entry.start) && (src_addr < range_end);
    result.dst_hit = (dst_addr >= entry.start) && (dst_addr < range_end);
  end

endmodule

// ----- hw/rtl/call_return_trace_unit.sv -----
// Call/return trace unit for retired jal/jalr instructions.
// Items enter on start while busy is low. cmd selects the kind of item:
//   load  - writes entry_start/entry_size into slot entry_index;
//           busy stays low and no result is produced.
//   trace - a jal/jalr with trace_enable set raises busy and scans the
//           function table one entry per cycle for the lowest entries that
//           hold pc and next_pc, then updates the nesting depth.
// A trace item reads at most min(entry_count, TABLE_ENTRIES) entries, fewer
// once both addresses have matched, through the single table read port and
// the shared range compare. A trace that is disabled or not a jump is
// dropped in the accept cycle.
// Results appear on the result ports for one cycle with done high, in the
// cycle busy falls; the receiver cannot stall them.
// Configuration writes go through cfg_valid/cfg_ready (always ready):
// index 0 trace_enable, index 1 entry_count. Write only while idle.
// Reset clears depth, configuration and control; table contents stay
// undefined until loaded.
module call_return_trace_unit #(
  parameter int TABLE_ENTRIES = crtu_pkg::TABLE_ENTRIES_DEF,
  parameter int DEPTH_LIMIT   = crtu_pkg::DEPTH_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd,
  input  logic [crtu_pkg::INDEX_W-1:0]        entry_index,
  input  logic [crtu_pkg::ADDR_W-1:0]         entry_start,
  input  logic [crtu_pkg::ADDR_W-1:0]         entry_size,
  input  logic [crtu_pkg::ADDR_W-1:0]         pc,
  input  logic [crtu_pkg::ADDR_W-1:0]         next_pc,
  input  logic [4:0]                          src_reg,
  input  logic [4:0]                          dest_reg,
  input  logic [crtu_pkg::ADDR_W-1:0]         imm,
  input  logic [1:0]                          op,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crtu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crtu_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                done,
  output logic                                is_return,
  output logic [crtu_pkg::ADDR_W-1:0]         source_pc,
  output logic [crtu_pkg::ADDR_W-1:0]         target_pc,
  output logic [crtu_pkg::DEPTH_W-1:0]        indent_depth,
  output logic                                source_found,
  output logic [crtu_pkg::INDEX_W-1:0]        source_index,
  output logic                                target_found,
  output logic [crtu_pkg::INDEX_W-1:0]        target_index
);
  import crtu_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state;
  logic                 trace_enable;
  logic [COUNT_W-1:0]   entry_count;
  logic [DEPTH_W-1:0]   nest_depth;

  logic [CNT_W-1:0]     ptr;
  logic                 pend;
  logic [IDX_W-1:0]     pend_idx;

  logic [ADDR_W-1:0]    pc_q;
  logic [ADDR_W-1:0]    npc_q;
  logic                 ret_cand;
  logic                 src_found;
  logic [IDX_W-1:0]     src_idx;
  logic                 dst_found;
  logic [IDX_W-1:0]     dst_idx;

  logic                 accept;
  logic                 trace_go;
  logic                 load_wr;
  logic [CNT_W-1:0]     limit;
  logic                 issue;
  logic                 finish;
  logic                 is_ret_next;
  logic [DEPTH_W-1:0]   depth_next;
  logic [DEPTH_W-1:0]   indent_next;

  entry_t               wr_entry;
  entry_t               rd_entry;
  match_t               hit;

  assign busy      = (state == ST_SCAN);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign trace_go  = accept && (cmd == CMD_TRACE) && trace_enable &&
                     ((op == OP_JAL) || (op == OP_JALR));
  assign load_wr   = accept && (cmd == CMD_LOAD) &&
                     (32'(entry_index) < 32'(TABLE_ENTRIES));

  assign limit  = (32'(entry_count) > 32'(TABLE_ENTRIES)) ?
                  CNT_W'(TABLE_ENTRIES) : CNT_W'(entry_count);
  assign issue  = busy && (ptr != limit) && !(src_found && dst_found);
  assign finish = busy && !issue && !pend;

  assign wr_entry.start = entry_start;
  assign wr_entry.size  = entry_size;

  crtu_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (IDX_W'(entry_index)),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (ptr[IDX_W-1:0]),
    .rd_data (rd_entry)
  );

  crtu_match u_match (
    .entry    (rd_entry),
    .src_addr (pc_q),
    .dst_addr (npc_q),
    .result   (hit)
  );

  // Depth update: a return needs nonzero depth, else it counts as a call
  always_comb begin
    is_ret_next = ret_cand && (nest_depth != '0);
    if (is_ret_next) begin
      depth_next  = nest_depth - 1'b1;
      indent_next = depth_next;
    end else begin
      depth_next  = (nest_depth < DEPTH_W'(DEPTH_LIMIT)) ? nest_depth + 1'b1 : nest_depth;
      indent_next = depth_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      trace_enable <= 1'b0;
      entry_count  <= '0;
      nest_depth   <= '0;
      pend         <= 1'b0;
      done         <= 1'b0;
      ptr          <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TRACE_ENABLE: trace_enable <= cfg_data[0];
          REG_ENTRY_COUNT:  entry_count  <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          pend <= 1'b0;
          if (trace_go) begin
            ptr   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend <= issue;
          if (issue) begin
            ptr <= ptr + 1'b1;
          end
          if (finish) begin
            nest_depth <= depth_next;
            done       <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (trace_go) begin
      pc_q      <= pc;
      npc_q     <= next_pc;
      ret_cand  <= (op == OP_JALR) && (src_reg == 5'd1) && (dest_reg == 5'd0) &&
                   (imm == '0);
      src_found <= 1'b0;
      src_idx   <= '0;
      dst_found <= 1'b0;
      dst_idx   <= '0;
    end else begin
      if (issue) begin
        pend_idx <= ptr[IDX_W-1:0];
      end
      // Keep the first (lowest) hit only
      if (pend && hit.src_hit && !src_found) begin
        src_found <= 1'b1;
        src_idx   <= pend_idx;
      end
      if (pend && hit.dst_hit && !dst_found) begin
        dst_found <= 1'b1;
        dst_idx   <= pend_idx;
      end
    end
    if (finish) begin
      is_return    <= is_ret_next;
      source_pc    <= pc_q;
      target_pc    <= npc_q;
      indent_depth <= indent_next;
      source_found <= src_found;
      source_index <= INDEX_W'(src_idx);
      target_found <= dst_found;
      target_index <= INDEX_W'(dst_idx);
    end
  end

  a_depth_limit: assert property (@(posedge clk) disable iff (rst)
    nest_depth <= DEPTH_W'(DEPTH_LIMIT))
    else $error("nesting depth above limit");

  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result without a finished scan");

  a_call_indent: assert property (@(posedge clk) disable iff (rst)
    done && !is_return |-> indent_depth < DEPTH_W'(DEPTH_LIMIT))
    else $error("call indent out of range");

  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    done && !source_found |-> source_index == '0)
    else $error("source index set without a match");

endmodule

// ----- bench/call_return_trace_unit_test.sv -----
module call_return_trace_unit_test;
  import crtu_pkg::*;

  localparam int SLOTS = TABLE_ENTRIES_DEF;
  localparam int DEPTH_CAP = DEPTH_LIMIT_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = SLOTS + 16;
  localparam int RANDOM_ITEMS = 150;
  localparam int CALM_TAIL = 50;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_RSVD = 2'd3;
  localparam logic [4:0] RA = 5'd1;
  localparam logic [4:0] ZERO_REG = 5'd0;

  typedef struct packed {
    logic                cmd;
    logic [INDEX_W-1:0]  entry_index;
    logic [ADDR_W-1:0]   entry_start;
    logic [ADDR_W-1:0]   entry_size;
    logic [ADDR_W-1:0]   pc;
    logic [ADDR_W-1:0]   next_pc;
    logic [4:0]          src_reg;
    logic [4:0]          dest_reg;
    logic [ADDR_W-1:0]   imm;
    logic [1:0]          op;
  } jump_item_t;

  typedef struct packed {
    logic                is_return;
    logic [ADDR_W-1:0]   source_pc;
    logic [ADDR_W-1:0]   target_pc;
    logic [DEPTH_W-1:0]  indent_depth;
    logic                source_found;
    logic [INDEX_W-1:0]  source_index;
    logic                target_found;
    logic [INDEX_W-1:0]  target_index;
  } trace_event_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   cmd = CMD_LOAD;
  logic [INDEX_W-1:0]     entry_index = '0;
  logic [ADDR_W-1:0]      entry_start = '0;
  logic [ADDR_W-1:0]      entry_size = '0;
  logic [ADDR_W-1:0]      pc = '0;
  logic [ADDR_W-1:0]      next_pc = '0;
  logic [4:0]             src_reg = '0;
  logic [4:0]             dest_reg = '0;
  logic [ADDR_W-1:0]      imm = '0;
  logic [1:0]             op = OP_NONE;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_TRACE_ENABLE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   done;
  logic                   is_return;
  logic [ADDR_W-1:0]      source_pc;
  logic [ADDR_W-1:0]      target_pc;
  logic [DEPTH_W-1:0]     indent_depth;
  logic                   source_found;
  logic [INDEX_W-1:0]     source_index;
  logic                   target_found;
  logic [INDEX_W-1:0]     target_index;

  // shadow of the block's state
  logic [ADDR_W-1:0]      range_lo [SLOTS];
  logic [ADDR_W-1:0]      range_len [SLOTS];
  logic [DEPTH_W-1:0]     call_level = '0;
  logic                   trace_on = 1'b0;
  logic [COUNT_W-1:0]     scan_count = '0;

  trace_event_t           pending_events [$];
  trace_event_t           want_ev;

  int fail_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int useful_items = 0;
  int results_checked = 0;
  int peak_level = 0;
  bit idle_on = 1'b1;

  call_return_trace_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .entry_start  (entry_start),
    .entry_size   (entry_size),
    .pc           (pc),
    .next_pc      (next_pc),
    .src_reg      (src_reg),
    .dest_reg     (dest_reg),
    .imm          (imm),
    .op           (op),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .is_return    (is_return),
    .source_pc    (source_pc),
    .target_pc    (target_pc),
    .indent_depth (indent_depth),
    .source_found (source_found),
    .source_index (source_index),
    .target_found (target_found),
    .target_index (target_index)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_events.size());
      $display("** call_return_trace_unit: FAILED **");
      $finish;
    end
  end

  // lowest searched slot whose range holds addr
  function automatic logic [INDEX_W-1:0] find_range(input logic [ADDR_W-1:0] addr,
                                                    output logic hit);
    int lim;
    logic [ADDR_W-1:0] hi;
    lim = (scan_count > SLOTS) ? SLOTS : int'(scan_count);
    for (int i = 0; i < lim; i++) begin
      hi = range_lo[i] + range_len[i];
      if (addr >= range_lo[i] && addr < hi) begin
        hit = 1'b1;
        return INDEX_W'(i);
      end
    end
    hit = 1'b0;
    return '0;
  endfunction

  task automatic track_item(input jump_item_t it);
    trace_event_t ev;
    items_sent++;
    if (it.cmd == CMD_LOAD) begin
      range_lo[it.entry_index] = it.entry_start;
      range_len[it.entry_index] = it.entry_size;
      loads_sent++;
      useful_items++;
      return;
    end
    if (!trace_on || (it.op != OP_JAL && it.op != OP_JALR))
      return;
    useful_items++;
    ev.source_pc = it.pc;
    ev.target_pc = it.next_pc;
    ev.source_index = find_range(it.pc, ev.source_found);
    ev.target_index = find_range(it.next_pc, ev.target_found);
    if (it.op == OP_JALR && it.src_reg == RA && it.dest_reg == ZERO_REG &&
        it.imm == '0 && call_level != '0) begin
      call_level--;
      ev.is_return = 1'b1;
      ev.indent_depth = call_level;
    end else begin
      if (call_level < DEPTH_CAP)
        call_level++;
      ev.is_return = 1'b0;
      ev.indent_depth = call_level - 1'b1;
    end
    if (call_level > peak_level)
      peak_level = call_level;
    pending_events.push_back(ev);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // sample mid-cycle so the result never races the driving edge
  always @(negedge clk) begin
    if (!rst && done) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: source_pc 0x%0h target_pc 0x%0h", source_pc, target_pc);
        fail_count++;
      end else begin
        want_ev = pending_events.pop_front();
        results_checked++;
        check_field("is_return", want_ev.is_return, is_return);
        check_field("source_pc", want_ev.source_pc, source_pc);
        check_field("target_pc", want_ev.target_pc, target_pc);
        check_field("indent_depth", want_ev.indent_depth, indent_depth);
        check_field("source_found", want_ev.source_found, source_found);
        check_field("source_index", want_ev.source_index, source_index);
        check_field("target_found", want_ev.target_found, target_found);
        check_field("target_index", want_ev.target_index, target_index);
      end
    end
  end

  // called and returns at a rising edge; the item is taken at the returning edge
  task automatic send_item(input jump_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= it.cmd;
    entry_index <= it.entry_index;
    entry_start <= it.entry_start;
    entry_size <= it.entry_size;
    pc <= it.pc;
    next_pc <= it.next_pc;
    src_reg <= it.src_reg;
    dest_reg <= it.dest_reg;
    imm <= it.imm;
    op <= it.op;
    @(negedge clk);
    while (busy) @(negedge clk);
    track_item(it);
    @(posedge clk);
  endtask

  // drop start and wait until the block has nothing left in flight
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending_events.size() != 0 || busy) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic en, input logic [COUNT_W-1:0] cnt);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TRACE_ENABLE;
    cfg_data <= CFG_DATA_W'(en);
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    trace_on = en;
    @(posedge clk);
    cfg_index <= REG_ENTRY_COUNT;
    cfg_data <= CFG_DATA_W'(cnt);
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    scan_count = cnt;
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic jump_item_t mk_load(input int slot, input logic [ADDR_W-1:0] lo,
                                         input logic [ADDR_W-1:0] len);
    jump_item_t it;
    it = '0;
    it.cmd = CMD_LOAD;
    it.entry_index = INDEX_W'(slot);
    it.entry_start = lo;
    it.entry_size = len;
    it.pc = $urandom;
    it.op = 2'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic jump_item_t mk_jump(input logic [1:0] kind, input logic [ADDR_W-1:0] from,
                                         input logic [ADDR_W-1:0] to, input logic [4:0] rs,
                                         input logic [4:0] rd, input logic [ADDR_W-1:0] offs);
    jump_item_t it;
    it = '0;
    it.cmd = CMD_TRACE;
    it.entry_index = INDEX_W'($urandom);
    it.entry_start = $urandom;
    it.entry_size = $urandom;
    it.pc = from;
    it.next_pc = to;
    it.src_reg = rs;
    it.dest_reg = rd;
    it.imm = offs;
    it.op = kind;
    return it;
  endfunction

  // address biased toward the edges and insides of searched ranges
  function automatic logic [ADDR_W-1:0] pick_addr();
    int lim;
    int j;
    int r;
    lim = (scan_count > SLOTS) ? SLOTS : int'(scan_count);
    j = (lim == 0) ? $urandom_range(0, SLOTS - 1) : $urandom_range(0, lim - 1);
    r = $urandom_range(0, 99);
    if (r < 50 && range_len[j] != '0)
      return range_lo[j] + ($urandom % range_len[j]);
    if (r < 62)
      return range_lo[j] + range_len[j];
    if (r < 70)
      return range_lo[j] - 1;
    if (r < 74)
      return '0;
    if (r < 78)
      return '1;
    return $urandom;
  endfunction

  function automatic jump_item_t ret_item();
    return mk_jump(OP_JALR, pick_addr(), pick_addr(), RA, ZERO_REG, '0);
  endfunction

  function automatic jump_item_t call_item();
    jump_item_t it;
    it = mk_jump($urandom_range(0, 1) ? OP_JAL : OP_JALR, pick_addr(), pick_addr(),
                 5'($urandom), 5'($urandom), $urandom);
    // never let a random call look like a return
    if (it.op == OP_JALR && it.src_reg == RA && it.dest_reg == ZERO_REG && it.imm == '0)
      it.imm = 32'd4;
    return it;
  endfunction

  function automatic jump_item_t rand_item();
    jump_item_t it;
    int r;
    int slot;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      slot = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 3) == 0)
        return mk_load(slot, $urandom, $urandom);
      return mk_load(slot, 32'h1000 + slot * 32'h100 + $urandom_range(0, 255),
                     $urandom_range(0, 1024));
    end
    if (r < 42)
      return ret_item();
    if (r < 54) begin
      it = ret_item();
      case ($urandom_range(0, 3))
        0: it.imm = 32'd1 << $urandom_range(0, 31);
        1: it.src_reg = RA ^ 5'($urandom_range(1, 31));
        2: it.dest_reg = 5'($urandom_range(1, 31));
        default: it.op = OP_JAL;
      endcase
      return it;
    end
    if (r < 60)
      return mk_jump($urandom_range(0, 1) ? OP_NONE : OP_RSVD, $urandom, $urandom,
                     RA, ZERO_REG, '0);
    return call_item();
  endfunction

  // straight after reset: tracing is off, so nothing comes back
  task automatic test_disabled();
    send_item(mk_jump(OP_JAL, 32'h100, 32'h200, 5'd0, RA, 32'h100));
    send_item(mk_jump(OP_JALR, 32'h204, 32'h104, RA, ZERO_REG, '0));
    send_item(mk_load(0, '0, 32'h10));
    send_item(mk_jump(OP_JALR, '1, '0, 5'd31, 5'd31, '1));
  endtask

  // no entries searched: every lookup misses, depth and kind still tracked
  task automatic test_empty_table();
    settle();
    set_config(1'b1, '0);
    send_item(ret_item());
    send_item(ret_item());
    send_item(mk_jump(OP_JAL, '0, '1, ZERO_REG, ZERO_REG, '0));
    send_item(mk_jump(OP_JALR, '1, '0, 5'd31, 5'd31, '1));
    send_item(mk_jump(OP_JALR, 32'h10, 32'h20, RA, ZERO_REG, 32'd1));
    send_item(mk_jump(OP_JALR, 32'h30, 32'h40, RA, RA, '0));
    send_item(mk_jump(OP_JALR, 32'h50, 32'h60, ZERO_REG, ZERO_REG, '0));
    send_item(mk_jump(OP_JAL, 32'h70, 32'h80, RA, ZERO_REG, '0));
    send_item(mk_jump(OP_NONE, 32'h90, 32'ha0, RA, ZERO_REG, '0));
    send_item(mk_jump(OP_RSVD, 32'hb0, 32'hc0, RA, ZERO_REG, '0));
    while (call_level != '0) send_item(ret_item());
  endtask

  // load every slot with tracing off; a few slots hold the range corner cases
  task automatic test_fill_table();
    settle();
    set_config(1'b0, '0);
    for (int i = 0; i < SLOTS; i++) begin
      case (i)
        0: send_item(mk_load(i, '0, 32'h10));
        1: send_item(mk_load(i, 32'hffff_fff0, 32'h10));       // end wraps to 0: empty
        2: send_item(mk_load(i, 32'hffff_ff00, 32'hff));
        3: send_item(mk_load(i, 32'h1000, '0));                // zero size: empty
        SLOTS - 1: send_item(mk_load(i, '0, '1));             // everything but the top
        default:
          if (i % 8 == 7)
            send_item(mk_load(i, $urandom, $urandom));
          else
            send_item(mk_load(i, 32'h1000 + i * 32'h100 + $urandom_range(0, 255),
                              $urandom_range(0, 768)));
      endcase
    end
  endtask

  task automatic test_range_edges();
    settle();
    set_config(1'b1, COUNT_W'(SLOTS));
    send_item(mk_jump(OP_JAL, 32'h0f, 32'h10, ZERO_REG, RA, 32'h10));
    send_item(mk_jump(OP_JAL, 32'hffff_fff0, '1, ZERO_REG, RA, 32'h20));
    send_item(mk_jump(OP_JAL, 32'hffff_ff00, 32'hffff_fffe, ZERO_REG, RA, 32'h30));
    send_item(mk_jump(OP_JAL, 32'h1000, range_lo[100], ZERO_REG, RA, 32'h40));
    send_item(mk_jump(OP_JAL, range_lo[200] + range_len[200] - 1,
                      range_lo[200] + range_len[200], ZERO_REG, RA, 32'h50));
    send_item(mk_jump(OP_JAL, range_lo[SLOTS - 2], range_lo[7] - 1, ZERO_REG, RA, 32'h60));
    while (call_level != '0) send_item(ret_item());
  endtask

  task automatic test_scan_extremes();
    settle();
    set_config(1'b1, COUNT_W'(1));
    repeat (15) send_item(rand_item());
    settle();
    set_config(1'b1, COUNT_W'(SLOTS));
    repeat (15) send_item(rand_item());
    settle();
    // counts past the table size clamp to the full table
    set_config(1'b1, '1);
    repeat (15) send_item(rand_item());
  endtask

  task automatic test_depth_limit();
    settle();
    set_config(1'b1, COUNT_W'(4));
    repeat (DEPTH_CAP + 6) send_item(call_item());
    repeat (3) send_item(ret_item());
    repeat (5) send_item(call_item());
    while (call_level != '0) send_item(ret_item());
    send_item(ret_item());
  endtask

  task automatic test_random_traffic();
    int goal;
    int n;
    int k;
    logic [COUNT_W-1:0] cnt;
    goal = useful_items + RANDOM_ITEMS;
    while (useful_items < goal) begin
      settle();
      k = $urandom_range(0, 9);
      if (k < 6)
        cnt = COUNT_W'($urandom_range(0, 32));
      else if (k < 8)
        cnt = COUNT_W'($urandom_range(33, SLOTS));
      else if (k < 9)
        cnt = COUNT_W'(SLOTS);
      else
        cnt = COUNT_W'($urandom_range(SLOTS + 1, 511));
      set_config($urandom_range(0, 6) != 0, cnt);
      idle_on = $urandom_range(0, 3) != 0;
      n = $urandom_range(40, 80);
      for (int i = 0; i < n && useful_items < goal; i++) begin
        if (useful_items >= goal - CALM_TAIL)
          idle_on = 1'b0;
        send_item(rand_item());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      range_lo[i] = '0;
      range_len[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_disabled();
    test_empty_table();
    test_fill_table();
    test_range_edges();
    test_scan_extremes();
    test_depth_limit();
    test_random_traffic();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d items (%0d table loads, %0d counted), checked %0d trace results",
             items_sent, loads_sent, useful_items, results_checked);
    $display("nesting reached %0d; entry counts from 0 up to 511 with tracing on and off",
             peak_level);
    if (fail_count == 0)
      $display("** call_return_trace_unit: PASSED **");
    else
      $display("** call_return_trace_unit: FAILED **");
    $finish;
  end

endmodule
